### rtl/entity_slot_allocator_core_macros.svh
// Assertion macros used by the checker file.
`ifndef ENTITY_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define ENTITY_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define ESA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esa: same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define ESA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esa: next-cycle check failed");

`endif

### rtl/esa_pkg.sv
package esa_pkg;

   localparam int SLOT_COUNT_DEF = 256;
   localparam int PAGE_SLOTS_DEF = 16;

   localparam int ID_W       = 32;
   localparam int SLOT_IDX_W = 8;
   localparam int STATUS_W   = 2;

   localparam logic [ID_W-1:0] ID_LAST = 32'hFFFF_FFFE;

   localparam logic KIND_CREATE  = 1'b0;
   localparam logic KIND_DESTROY = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_UNKNOWN = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PAGE,
      ST_POP,
      ST_BIND,
      ST_RESULT
   } state_type;

endpackage

### rtl/esa_req_if.sv
interface esa_req_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [esa_pkg::ID_W-1:0]  target_id;

   modport source (output valid, output kind, output target_id, input ready);
   modport sink   (input valid, input kind, input target_id, output ready);
endinterface

### rtl/esa_rsp_if.sv
interface esa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [esa_pkg::ID_W-1:0]        assigned_id;
   logic [esa_pkg::SLOT_IDX_W-1:0]  slot_index;
   logic [esa_pkg::STATUS_W-1:0]    status;

   modport source (output valid, output assigned_id, output slot_index, output status,
                   input ready);
   modport sink   (input valid, input assigned_id, input slot_index, input status,
                   output ready);
endinterface

### rtl/esa_ram.sv
module esa_ram #(
   parameter int WIDTH = esa_pkg::ID_W,
   parameter int DEPTH = esa_pkg::SLOT_COUNT_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/esa_match.sv
// Compare stage of the owner scan: checks the slot whose read was issued in the cycle before.
module esa_match #(
   parameter int SLOT_COUNT = esa_pkg::SLOT_COUNT_DEF,
   localparam int LINK_W = $clog2(SLOT_COUNT + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     issue,
   input  logic [LINK_W-1:0]        issue_idx,
   input  logic [esa_pkg::ID_W-1:0] key,
   input  logic                     used_bit,
   input  logic [esa_pkg::ID_W-1:0] owner_id,
   output logic                     hit,
   output logic [LINK_W-1:0]        hit_idx
);

   logic              chk_vld_ff;
   logic              chk_vld_in;
   logic [LINK_W-1:0] chk_idx_ff;
   logic [LINK_W-1:0] chk_idx_in;

   assign chk_vld_in = issue;
   assign chk_idx_in = issue_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
      end else begin
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
   end

   assign hit     = chk_vld_ff && used_bit && (owner_id == key);
   assign hit_idx = chk_idx_ff;

endmodule

### rtl/entity_slot_allocator_core.sv
// Channel  Dir  Payload                              Handshake
// req_chan in   kind, target_id                      valid/ready
// rsp_chan out  assigned_id, slot_index, status      valid/ready
//
// One transaction at a time; req_chan.ready is high only when idle.
// Per item: accept, the owner scan, then loading rsp (a full create skips the scan).
// Scan pass, one slot per cycle, ends at a hit or after the last paged slot;
// create repeats the pass for every candidate id already owned.
// Create then links the slots of a new page if the free list is empty, then pops and binds.
// Reset clears head, page limit and candidate; slots are rewritten as pages are taken.
// A stalled rsp_chan holds one result in rsp and a second in the result register.
module entity_slot_allocator_core #(
   parameter int SLOT_COUNT = esa_pkg::SLOT_COUNT_DEF,
   parameter int PAGE_SLOTS = esa_pkg::PAGE_SLOTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   esa_req_if.sink   req_chan,
   esa_rsp_if.source rsp_chan
);

   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int LINK_W  = $clog2(SLOT_COUNT + 1);
   localparam int META_W  = LINK_W + 1;
   localparam int SUM_W   = $clog2(SLOT_COUNT + PAGE_SLOTS + 1);
   localparam int ID_W    = esa_pkg::ID_W;
   localparam int OUT_W   = esa_pkg::SLOT_IDX_W;

   esa_pkg::state_type  state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [ID_W-1:0]     key_ff, key_in;
   logic [ID_W-1:0]     cand_ff, cand_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [LINK_W-1:0]   limit_ff, limit_in;
   logic [LINK_W-1:0]   scan_ff, scan_in;
   logic [LINK_W-1:0]   page_end_ff, page_end_in;
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   logic [OUT_W-1:0]    res_slot_ff, res_slot_in;
   esa_pkg::status_type res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [OUT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   esa_pkg::status_type rsp_status_ff, rsp_status_in;

   logic                issue;
   logic                hit;
   logic [LINK_W-1:0]   hit_idx;
   logic [ID_W-1:0]     match_key;
   logic                full;
   logic [SUM_W-1:0]    page_sum;
   logic [LINK_W-1:0]   page_end_calc;
   logic [LINK_W-1:0]   scan_next;

   logic [SLOT_W-1:0]   rd_addr;
   logic [SLOT_W-1:0]   wr_addr;
   logic                meta_wr_en;
   logic [META_W-1:0]   meta_wr_data;
   logic [META_W-1:0]   meta_rd_data;
   logic                owner_wr_en;
   logic [ID_W-1:0]     owner_rd_data;

   // meta word: {used, next link}
   esa_ram #(.WIDTH(META_W), .DEPTH(SLOT_COUNT)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (wr_addr),
      .wr_data (meta_wr_data),
      .rd_addr (rd_addr),
      .rd_data (meta_rd_data)
   );

   esa_ram #(.WIDTH(ID_W), .DEPTH(SLOT_COUNT)) u_owner_ram (
      .clock   (clock),
      .wr_en   (owner_wr_en),
      .wr_addr (wr_addr),
      .wr_data (cand_ff),
      .rd_addr (rd_addr),
      .rd_data (owner_rd_data)
   );

   assign match_key = (kind_ff == esa_pkg::KIND_DESTROY) ? key_ff : cand_ff;

   esa_match #(.SLOT_COUNT(SLOT_COUNT)) u_match (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .issue_idx (scan_ff),
      .key       (match_key),
      .used_bit  (meta_rd_data[META_W-1]),
      .owner_id  (owner_rd_data),
      .hit       (hit),
      .hit_idx   (hit_idx)
   );

   assign full = (head_ff >= limit_ff) && (limit_ff >= LINK_W'(SLOT_COUNT));
   assign page_sum = SUM_W'(limit_ff) + SUM_W'(PAGE_SLOTS);
   assign page_end_calc = (page_sum > SUM_W'(SLOT_COUNT)) ? LINK_W'(SLOT_COUNT)
                                                         : LINK_W'(page_sum);
   assign scan_next = scan_ff + LINK_W'(1);

   assign req_chan.ready       = (state_ff == esa_pkg::ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.assigned_id = rsp_id_ff;
   assign rsp_chan.slot_index  = rsp_slot_ff;
   assign rsp_chan.status      = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      cand_in       = cand_ff;
      head_in       = head_ff;
      limit_in      = limit_ff;
      scan_in       = scan_ff;
      page_end_in   = page_end_ff;
      res_id_in     = res_id_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      issue         = 1'b0;
      rd_addr       = scan_ff[SLOT_W-1:0];
      wr_addr       = scan_ff[SLOT_W-1:0];
      meta_wr_en    = 1'b0;
      meta_wr_data  = {1'b0, scan_next};
      owner_wr_en   = 1'b0;

      case (state_ff)
         esa_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               kind_in = req_chan.kind;
               key_in  = req_chan.target_id;
               scan_in = '0;
               if (req_chan.kind == esa_pkg::KIND_CREATE && full) begin
                  res_id_in     = '0;
                  res_slot_in   = '0;
                  res_status_in = esa_pkg::STATUS_FULL;
                  state_in      = esa_pkg::ST_RESULT;
               end else begin
                  state_in = esa_pkg::ST_SCAN;
               end
            end
         end

         esa_pkg::ST_SCAN: begin
            if (hit) begin
               if (kind_ff == esa_pkg::KIND_CREATE) begin
                  // candidate taken: step past it, skipping the invalid id
                  cand_in = (cand_ff >= esa_pkg::ID_LAST) ? '0 : cand_ff + ID_W'(1);
                  scan_in = '0;
               end else begin
                  meta_wr_en    = 1'b1;
                  wr_addr       = hit_idx[SLOT_W-1:0];
                  meta_wr_data  = {1'b0, head_ff};
                  head_in       = hit_idx;
                  res_id_in     = key_ff;
                  res_slot_in   = OUT_W'(hit_idx);
                  res_status_in = esa_pkg::STATUS_OK;
                  state_in      = esa_pkg::ST_RESULT;
               end
            end else if (scan_ff >= limit_ff) begin
               if (kind_ff == esa_pkg::KIND_CREATE) begin
                  if (head_ff >= limit_ff) begin
                     page_end_in = page_end_calc;
                     scan_in     = limit_ff;
                     state_in    = esa_pkg::ST_PAGE;
                  end else begin
                     state_in = esa_pkg::ST_POP;
                  end
               end else begin
                  res_id_in     = key_ff;
                  res_slot_in   = '0;
                  res_status_in = esa_pkg::STATUS_UNKNOWN;
                  state_in      = esa_pkg::ST_RESULT;
               end
            end else begin
               issue   = 1'b1;
               scan_in = scan_next;
            end
         end

         esa_pkg::ST_PAGE: begin
            // link each new slot to the next index and mark it free
            meta_wr_en = 1'b1;
            if (scan_next == page_end_ff) begin
               head_in  = limit_ff;
               limit_in = page_end_ff;
               state_in = esa_pkg::ST_POP;
            end else begin
               scan_in = scan_next;
            end
         end

         esa_pkg::ST_POP: begin
            rd_addr  = head_ff[SLOT_W-1:0];
            state_in = esa_pkg::ST_BIND;
         end

         esa_pkg::ST_BIND: begin
            wr_addr       = head_ff[SLOT_W-1:0];
            meta_wr_en    = 1'b1;
            meta_wr_data  = {1'b1, meta_rd_data[LINK_W-1:0]};
            owner_wr_en   = 1'b1;
            head_in       = meta_rd_data[LINK_W-1:0];
            res_id_in     = cand_ff;
            res_slot_in   = OUT_W'(head_ff);
            res_status_in = esa_pkg::STATUS_OK;
            state_in      = esa_pkg::ST_RESULT;
         end

         esa_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = res_id_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               state_in      = esa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = esa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cand_ff      <= '0;
         head_ff      <= '0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cand_ff      <= cand_in;
         head_ff      <= head_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      scan_ff       <= scan_in;
      page_end_ff   <= page_end_in;
      res_id_ff     <= res_id_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

### rtl/esa_checker.sv
`include "entity_slot_allocator_core_macros.svh"

module esa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [esa_pkg::ID_W-1:0]       rsp_assigned_id,
   input logic [esa_pkg::SLOT_IDX_W-1:0] rsp_slot_index,
   input logic [esa_pkg::STATUS_W-1:0]   rsp_status
);

   // one transaction in flight: busy right after an accept
   `ESA_ASSERT_NEXT(busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a full store reports no id and no slot
   `ESA_ASSERT_SAME(full_is_zero, clock, reset, rsp_valid && rsp_status == esa_pkg::STATUS_FULL, rsp_assigned_id == '0 && rsp_slot_index == '0)

   // an unknown id releases no slot
   `ESA_ASSERT_SAME(unknown_no_slot, clock, reset, rsp_valid && rsp_status == esa_pkg::STATUS_UNKNOWN, rsp_slot_index == '0)

   // stalled result holds
   `ESA_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_assigned_id) && $stable(rsp_slot_index) && $stable(rsp_status))

endmodule

bind entity_slot_allocator_core esa_checker u_esa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_assigned_id (rsp_chan.assigned_id),
   .rsp_slot_index  (rsp_chan.slot_index),
   .rsp_status      (rsp_chan.status)
);

### test/tb_entity_slot_allocator_core.sv
`timescale 1ns / 100ps

module tb_entity_slot_allocator_core;

   localparam int SLOTS       = esa_pkg::SLOT_COUNT_DEF;
   localparam int PAGE        = esa_pkg::PAGE_SLOTS_DEF;
   localparam int ID_W        = esa_pkg::ID_W;
   localparam int SLOT_IDX_W  = esa_pkg::SLOT_IDX_W;
   localparam int HOLD_CYCLES = 400;
   localparam int SEGMENTS    = 15;
   localparam int SEG_ITEMS   = 100;
   localparam longint WATCHDOG_NS = 200_000_000;

   typedef struct packed {
      logic [ID_W-1:0]       assigned_id;
      logic [SLOT_IDX_W-1:0] slot_index;
      esa_pkg::status_type   status;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset;

   esa_req_if req_if ();
   esa_rsp_if rsp_if ();

   entity_slot_allocator_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Allocator shadow state
   int unsigned     link_mem  [SLOTS];
   logic [ID_W-1:0] owner_mem [SLOTS];
   bit              used_mem  [SLOTS];
   int unsigned     free_head;
   int unsigned     pages_taken;
   logic [ID_W-1:0] id_cand;
   logic [ID_W-1:0] live_ids [$];

   alloc_result_type pending_results [$];

   int error_count;
   int n_create, n_destroy, n_full, n_unknown;
   int hold_requests;
   bit burst_mode;

   function automatic int unsigned owner_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (used_mem[i] && owner_mem[i] == id) return i;
      return SLOTS;
   endfunction

   function automatic int unsigned paged_end();
      int unsigned lim;
      lim = pages_taken * PAGE;
      return (lim > SLOTS) ? SLOTS : lim;
   endfunction

   function automatic void take_page();
      int unsigned base;
      int unsigned last;
      base = paged_end();
      last = (base + PAGE > SLOTS) ? SLOTS : base + PAGE;
      for (int unsigned i = base; i < last; i++) link_mem[i] = i + 1;
      free_head = base;
      pages_taken++;
   endfunction

   function automatic alloc_result_type compute_alloc_result(logic kind,
                                                             logic [ID_W-1:0] eid);
      alloc_result_type res;
      int unsigned      slot;
      res.assigned_id = '0;
      res.slot_index  = '0;
      res.status      = esa_pkg::STATUS_OK;
      if (kind == esa_pkg::KIND_CREATE) begin
         if (free_head >= paged_end() && paged_end() >= SLOTS) begin
            res.status = esa_pkg::STATUS_FULL;
         end else begin
            // skip past ids still owned; wrap below the invalid id
            while (owner_slot(id_cand) < SLOTS)
               id_cand = (id_cand >= esa_pkg::ID_LAST) ? '0 : id_cand + 1'b1;
            if (free_head >= paged_end()) take_page();
            slot            = free_head;
            free_head       = link_mem[slot];
            used_mem[slot]  = 1'b1;
            owner_mem[slot] = id_cand;
            res.assigned_id = id_cand;
            res.slot_index  = slot[SLOT_IDX_W-1:0];
            live_ids.push_back(id_cand);
         end
      end else begin
         slot            = owner_slot(eid);
         res.assigned_id = eid;
         if (slot >= SLOTS) begin
            res.status = esa_pkg::STATUS_UNKNOWN;
         end else begin
            used_mem[slot] = 1'b0;
            link_mem[slot] = free_head;
            free_head      = slot;
            res.slot_index = slot[SLOT_IDX_W-1:0];
            foreach (live_ids[i])
               if (live_ids[i] == eid) begin
                  live_ids.delete(i);
                  break;
               end
         end
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Called at a rising edge; returns at the edge where the transaction is taken.
   task automatic send_item(logic kind, logic [ID_W-1:0] eid, int gap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.kind      <= kind;
      req_if.target_id <= eid;
      do @(posedge clock); while (!req_if.ready);
      pending_results.push_back(compute_alloc_result(kind, eid));
   endtask

   task automatic send_create();
      send_item(esa_pkg::KIND_CREATE, $urandom(), pick_gap());
   endtask

   task automatic send_destroy();
      logic [ID_W-1:0] eid;
      int r;
      r = $urandom_range(0, 99);
      if (live_ids.size() > 0 && r < 75)
         eid = live_ids[$urandom_range(0, live_ids.size() - 1)];
      else if (r < 88)
         eid = $urandom();
      else
         eid = id_cand - $urandom_range(0, 3);
      send_item(esa_pkg::KIND_DESTROY, eid, pick_gap());
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(esa_pkg::KIND_DESTROY, 32'hFFFF_FFFF, 0);
      send_item(esa_pkg::KIND_DESTROY, 32'h0000_0000, 1);
      send_item(esa_pkg::KIND_CREATE, 32'hFFFF_FFFF, 0);
      send_item(esa_pkg::KIND_CREATE, 32'h0000_0000, 0);
      send_item(esa_pkg::KIND_CREATE, 32'hA5A5_5A5A, 2);
      send_item(esa_pkg::KIND_DESTROY, 32'h0000_0001, 0);
      send_item(esa_pkg::KIND_DESTROY, 32'h0000_0001, 0);
      send_item(esa_pkg::KIND_DESTROY, 32'h8000_0000, 3);
      send_item(esa_pkg::KIND_DESTROY, esa_pkg::ID_LAST, 0);
      send_item(esa_pkg::KIND_DESTROY, 32'hFFFF_FFFF, 0);
      send_item(esa_pkg::KIND_CREATE, 32'h5A5A_A5A5, 0);
      send_item(esa_pkg::KIND_DESTROY, 32'h0000_0000, 1);
      send_item(esa_pkg::KIND_CREATE, 32'h0000_0000, 0);
      send_item(esa_pkg::KIND_DESTROY, 32'h0000_0002, 0);
      send_item(esa_pkg::KIND_DESTROY, 32'h0000_0003, 0);
      send_item(esa_pkg::KIND_CREATE, 32'h1234_5678, 4);
      wait_idle();
   endtask

   task automatic test_fill_to_full();
      while (live_ids.size() < SLOTS) send_create();
      // store is full: these must report full and change nothing
      repeat (3) send_create();
      repeat (4) send_item(esa_pkg::KIND_DESTROY,
                           live_ids[$urandom_range(0, live_ids.size() - 1)], pick_gap());
      repeat (5) send_create();
      wait_idle();
   endtask

   task automatic test_backpressure();
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 2) send_item(esa_pkg::KIND_DESTROY, $urandom(), 0);
         else            send_item(esa_pkg::KIND_CREATE, $urandom(), 0);
      end
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int create_pct;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         create_pct = (seg % 2 == 0) ? 75 : 30;
         burst_mode = (seg % 5 == 3);
         for (int i = 0; i < SEG_ITEMS; i++) begin
            if ($urandom_range(0, 99) < create_pct) send_create();
            else                                   send_destroy();
         end
         burst_mode = 1'b0;
         if (seg % 4 == 1) wait_idle();
      end
      wait_idle();
   endtask

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.kind      <= esa_pkg::KIND_CREATE;
      req_if.target_id <= '0;
      for (int i = 0; i < SLOTS; i++) begin
         link_mem[i]  = 0;
         owner_mem[i] = '0;
         used_mem[i]  = 1'b0;
      end
      free_head   = 0;
      pages_taken = 0;
      id_cand     = '0;
      error_count = 0;
      burst_mode  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fill_to_full();
      test_backpressure();
      test_random_traffic();

      repeat (40) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         error_count++;
      end
      $display("Checked %0d creates and %0d destroys against the free-list predictor,",
               n_create, n_destroy);
      $display("including %0d full-store and %0d unknown-id responses.", n_full, n_unknown);
      if (error_count == 0) $display("PASS");
      else                  $display("FAIL");
      $finish;
   end

   initial begin
      hold_requests = 0;
   end

   // Response ready: random stalls, plus long holds on request.
   initial begin
      int stall_left;
      int hold_left;
      int holds_seen;
      stall_left = 0;
      hold_left  = 0;
      holds_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: id %0h slot %0d status %0d",
                   rsp_if.assigned_id, rsp_if.slot_index, rsp_if.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.assigned_id !== want.assigned_id) begin
               $error("assigned_id: expected %0h, got %0h", want.assigned_id,
                      rsp_if.assigned_id);
               error_count++;
            end
            if (rsp_if.slot_index !== want.slot_index) begin
               $error("slot_index: expected %0d, got %0d", want.slot_index,
                      rsp_if.slot_index);
               error_count++;
            end
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_if.status);
               error_count++;
            end
            case (want.status)
               esa_pkg::STATUS_FULL:    n_full++;
               esa_pkg::STATUS_UNKNOWN: n_unknown++;
               default: ;
            endcase
         end
      end
   end

   // Count transactions taken on the request side.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         if (req_if.kind == esa_pkg::KIND_CREATE) n_create++;
         else                                     n_destroy++;
      end
   end

   initial begin
      #(WATCHDOG_NS);
      $display("FAIL");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/esa_pkg.sv
rtl/esa_req_if.sv
rtl/esa_rsp_if.sv
rtl/esa_ram.sv
rtl/esa_match.sv
rtl/entity_slot_allocator_core.sv
rtl/esa_checker.sv
test/tb_entity_slot_allocator_core.sv
